// File: hw/rtl/irpd_pkg.sv
// irpd_pkg: types, constants and helpers shared by the ir pulse distance transmitter
// no dependencies
`default_nettype none

package irpd_pkg;

  localparam int TICKS_PER_US  = 8;
  localparam int CODE_BITS     = 48;
  localparam int FRAME_REPEATS = 2;

  localparam int DATA_W = 48;
  localparam int HP_W   = 16;
  localparam int US_W   = 13;
  localparam int SUB_W  = (TICKS_PER_US > 1) ? $clog2(TICKS_PER_US) : 1;
  localparam int BC_W   = $clog2(CODE_BITS + 1);
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 16;
  localparam int OUT_W  = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_HALF_PERIOD  = 3'd0,
    REG_LEADER_MARK  = 3'd1,
    REG_LEADER_SPACE = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_ZERO_SPACE   = 3'd5,
    REG_STOP_SPACE   = 3'd6
  } reg_idx_t;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_LEAD_MARK  = 7'b0000010,
    PH_LEAD_SPACE = 7'b0000100,
    PH_BIT_MARK   = 7'b0001000,
    PH_BIT_SPACE  = 7'b0010000,
    PH_STOP_MARK  = 7'b0100000,
    PH_STOP_SPACE = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [HP_W-1:0] half_period;
    logic [US_W-1:0] leader_mark;
    logic [US_W-1:0] leader_space;
    logic [US_W-1:0] bit_mark;
    logic [US_W-1:0] one_space;
    logic [US_W-1:0] zero_space;
    logic [US_W-1:0] stop_space;
  } cfg_t;

  typedef struct packed {
    logic rejected;
    logic done_res;
    logic busy_res;
    logic envelope;
    logic ir_out;
  } res_t;

  function automatic logic is_mark(phase_t p);
    return p inside {PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK};
  endfunction

  function automatic logic [US_W-1:0] nz_dur(logic [US_W-1:0] d);
    return (d == '0) ? US_W'(1) : d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ir_pulse_distance_transmitter.sv
// ir_pulse_distance_transmitter: top level, stream ports, config port, result register
// depends on irpd_pkg, irpd_cfg, irpd_core
//
// channel  direction  handshake           payload
// s_*      in         s_tvalid/s_tready   tuser action, tdata frame_data
// m_*      out        m_tvalid/m_tready   tdata result flags
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one request per clock cycle while s_tready is high, result valid in the cycle after it is taken
// the state update and the result register are loaded together on each request
// s_tready is high while the result register is empty or being drained
// synchronous active-high reset restores register defaults and the idle state
// cfg_ready is always high
`default_nettype none

module ir_pulse_distance_transmitter (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [irpd_pkg::DATA_W-1:0]  s_tdata,   // frame_data[47:0]
  input  wire logic                         s_tuser,   // action
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [irpd_pkg::OUT_W-1:0]        m_tdata,   // ir_out, envelope, busy_res,
                                                       // done_res, rejected, zero pad
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [irpd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]   cfg_data
);
  import irpd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  irpd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .action     (s_tuser),
    .frame_data (s_tdata),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_tdata = {(OUT_W - $bits(res_t))'(0), res_q};

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.rejected |-> res_q.busy_res && !res_q.envelope)
    else $error("rejected request without busy result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.done_res |-> !res_q.busy_res && !res_q.rejected)
    else $error("done reported while still busy");

  a_ir_env: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.ir_out |-> res_q.envelope && res_q.busy_res)
    else $error("emitter driven outside a mark");

  a_take: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("taken request produced no result");

endmodule

`default_nettype wire

// File: hw/rtl/irpd_cfg.sv
// irpd_cfg: configuration register file with reset values
// depends on irpd_pkg
`default_nettype none

module irpd_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [irpd_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]  wr_data,
  output irpd_pkg::cfg_t                   cfg
);
  import irpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period  <= HP_W'(105);
      cfg.leader_mark  <= US_W'(4550);
      cfg.leader_space <= US_W'(4350);
      cfg.bit_mark     <= US_W'(620);
      cfg.one_space    <= US_W'(460);
      cfg.zero_space   <= US_W'(1550);
      cfg.stop_space   <= US_W'(5100);
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_HALF_PERIOD:  cfg.half_period  <= wr_data[HP_W-1:0];
        REG_LEADER_MARK:  cfg.leader_mark  <= wr_data[US_W-1:0];
        REG_LEADER_SPACE: cfg.leader_space <= wr_data[US_W-1:0];
        REG_BIT_MARK:     cfg.bit_mark     <= wr_data[US_W-1:0];
        REG_ONE_SPACE:    cfg.one_space    <= wr_data[US_W-1:0];
        REG_ZERO_SPACE:   cfg.zero_space   <= wr_data[US_W-1:0];
        REG_STOP_SPACE:   cfg.stop_space   <= wr_data[US_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/irpd_core.sv
// irpd_core: segment sequencer, microsecond timer and carrier generator
// depends on irpd_pkg; steps once per accepted request
`default_nettype none

module irpd_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         action,
  input  wire logic [irpd_pkg::DATA_W-1:0]  frame_data,
  input  wire irpd_pkg::cfg_t               cfg,
  output irpd_pkg::res_t                    res
);
  import irpd_pkg::*;

  phase_t               phase, phase_next;
  logic [CODE_BITS-1:0] code_shift, code_shift_next;
  logic [BC_W-1:0]      bit_count, bit_count_next;
  logic                 frame_index, frame_index_next;
  logic [US_W-1:0]      us_remaining, us_remaining_next;
  logic [SUB_W-1:0]     subtick_count, subtick_count_next;
  logic [HP_W-1:0]      carrier_count, carrier_count_next;
  logic                 carrier_level, carrier_level_next;

  always_comb begin
    logic            seg_start;
    phase_t          seg_phase;
    logic [US_W-1:0] seg_dur;
    logic [HP_W-1:0] hp;
    logic [HP_W:0]   cc_inc;
    logic [SUB_W:0]  sub_inc;
    logic [US_W-1:0] us_dec;
    logic            top;
    logic [BC_W:0]   bc_inc;

    phase_next         = phase;
    code_shift_next    = code_shift;
    bit_count_next     = bit_count;
    frame_index_next   = frame_index;
    us_remaining_next  = us_remaining;
    subtick_count_next = subtick_count;
    carrier_count_next = carrier_count;
    carrier_level_next = carrier_level;
    res                = '0;
    seg_start          = 1'b0;
    seg_phase          = PH_IDLE;
    seg_dur            = '0;
    hp      = (cfg.half_period == '0) ? HP_W'(1) : cfg.half_period;
    cc_inc  = {1'b0, carrier_count} + (HP_W+1)'(1);
    sub_inc = {1'b0, subtick_count} + (SUB_W+1)'(1);
    us_dec  = (us_remaining != '0) ? us_remaining - US_W'(1) : us_remaining;
    top     = code_shift[CODE_BITS-1];
    bc_inc  = {1'b0, bit_count} + (BC_W+1)'(1);

    if (action) begin
      if (phase != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        code_shift_next  = CODE_BITS'(frame_data);
        frame_index_next = 1'b0;
        bit_count_next   = '0;
        seg_start        = 1'b1;
        seg_phase        = PH_LEAD_MARK;
        seg_dur          = cfg.leader_mark;
      end
    end else if (phase != PH_IDLE) begin
      if (is_mark(phase)) begin
        res.envelope = 1'b1;
        res.ir_out   = carrier_level;
        if (cc_inc >= {1'b0, hp}) begin
          carrier_count_next = '0;
          carrier_level_next = ~carrier_level;
        end else begin
          carrier_count_next = cc_inc[HP_W-1:0];
        end
      end
      if (sub_inc >= (SUB_W+1)'(TICKS_PER_US)) begin
        subtick_count_next = '0;
        us_remaining_next  = us_dec;
        if (us_dec == '0) begin
          case (phase)
            PH_LEAD_MARK: begin
              seg_start = 1'b1;
              seg_phase = PH_LEAD_SPACE;
              seg_dur   = cfg.leader_space;
            end
            PH_LEAD_SPACE: begin
              bit_count_next = '0;
              seg_start      = 1'b1;
              seg_phase      = PH_BIT_MARK;
              seg_dur        = cfg.bit_mark;
            end
            PH_BIT_MARK: begin
              seg_start = 1'b1;
              seg_phase = PH_BIT_SPACE;
              seg_dur   = top ? cfg.one_space : cfg.zero_space;
            end
            PH_BIT_SPACE: begin
              code_shift_next = {code_shift[CODE_BITS-2:0], top};
              bit_count_next  = bc_inc[BC_W-1:0];
              if (bc_inc < (BC_W+1)'(CODE_BITS)) begin
                seg_start = 1'b1;
                seg_phase = PH_BIT_MARK;
                seg_dur   = cfg.bit_mark;
              end else if (32'(frame_index) + 32'd1 < 32'(FRAME_REPEATS)) begin
                seg_start = 1'b1;
                seg_phase = PH_STOP_MARK;
                seg_dur   = cfg.bit_mark;
              end else begin
                phase_next         = PH_IDLE;
                frame_index_next   = 1'b0;
                bit_count_next     = '0;
                us_remaining_next  = '0;
                subtick_count_next = '0;
                carrier_count_next = '0;
                carrier_level_next = 1'b0;
                res.done_res       = 1'b1;
              end
            end
            PH_STOP_MARK: begin
              seg_start = 1'b1;
              seg_phase = PH_STOP_SPACE;
              seg_dur   = cfg.stop_space;
            end
            PH_STOP_SPACE: begin
              frame_index_next = 1'b1;
              seg_start        = 1'b1;
              seg_phase        = PH_LEAD_MARK;
              seg_dur          = cfg.leader_mark;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end else begin
        subtick_count_next = sub_inc[SUB_W-1:0];
      end
    end

    if (seg_start) begin
      phase_next         = seg_phase;
      us_remaining_next  = nz_dur(seg_dur);
      subtick_count_next = '0;
      if (is_mark(seg_phase)) begin
        carrier_count_next = '0;
        carrier_level_next = 1'b1;
      end
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      code_shift    <= '0;
      bit_count     <= '0;
      frame_index   <= 1'b0;
      us_remaining  <= '0;
      subtick_count <= '0;
      carrier_count <= '0;
      carrier_level <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      code_shift    <= code_shift_next;
      bit_count     <= bit_count_next;
      frame_index   <= frame_index_next;
      us_remaining  <= us_remaining_next;
      subtick_count <= subtick_count_next;
      carrier_count <= carrier_count_next;
      carrier_level <= carrier_level_next;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_ir_pulse_distance_transmitter.sv
// tb_ir_pulse_distance_transmitter: self-checking testbench for the ir pulse distance transmitter
// drives tick and start requests plus register writes, predicts every result flag set
// depends on irpd_pkg and ir_pulse_distance_transmitter
`timescale 1ns / 1ps

module tb_ir_pulse_distance_transmitter;
  import irpd_pkg::*;

  localparam bit ACT_TICK  = 1'b0;
  localparam bit ACT_START = 1'b1;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 2;
  localparam int TAIL_CYCLES   = 8;

  class ir_frame_scoreboard;
    cfg_t                 cfg;
    phase_t               ph;
    logic [CODE_BITS-1:0] code;
    int unsigned          bits, frame, remaining, sub, carrier;
    bit                   level;
    res_t                 pending_flags[$];
    int                   accepted, results_seen, mismatches;

    function new();
      cfg.half_period  = 16'd105;
      cfg.leader_mark  = 13'd4550;
      cfg.leader_space = 13'd4350;
      cfg.bit_mark     = 13'd620;
      cfg.one_space    = 13'd460;
      cfg.zero_space   = 13'd1550;
      cfg.stop_space   = 13'd5100;
      ph = PH_IDLE;
      code = '0;
      bits = 0; frame = 0; remaining = 0; sub = 0; carrier = 0; level = 0;
      accepted = 0; results_seen = 0; mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_HALF_PERIOD:  cfg.half_period  = value;
        REG_LEADER_MARK:  cfg.leader_mark  = value[US_W-1:0];
        REG_LEADER_SPACE: cfg.leader_space = value[US_W-1:0];
        REG_BIT_MARK:     cfg.bit_mark     = value[US_W-1:0];
        REG_ONE_SPACE:    cfg.one_space    = value[US_W-1:0];
        REG_ZERO_SPACE:   cfg.zero_space   = value[US_W-1:0];
        REG_STOP_SPACE:   cfg.stop_space   = value[US_W-1:0];
        default: ;
      endcase
    endfunction

    function bit carrier_gated(phase_t p);
      return p == PH_LEAD_MARK || p == PH_BIT_MARK || p == PH_STOP_MARK;
    endfunction

    function void enter(phase_t p, logic [US_W-1:0] dur);
      ph = p;
      remaining = (dur == '0) ? 1 : dur;
      sub = 0;
      if (carrier_gated(p)) begin
        carrier = 0;
        level = 1'b1;
      end
    endfunction

    // segment ran out: move on, returns 1 when the whole transmission ends
    function bit advance();
      bit top;
      top = code[CODE_BITS-1];
      case (ph)
        PH_LEAD_MARK:  enter(PH_LEAD_SPACE, cfg.leader_space);
        PH_LEAD_SPACE: begin
          bits = 0;
          enter(PH_BIT_MARK, cfg.bit_mark);
        end
        PH_BIT_MARK:   enter(PH_BIT_SPACE, top ? cfg.one_space : cfg.zero_space);
        PH_BIT_SPACE: begin
          code = {code[CODE_BITS-2:0], top};
          bits++;
          if (bits < CODE_BITS) begin
            enter(PH_BIT_MARK, cfg.bit_mark);
          end else if (frame + 1 < FRAME_REPEATS) begin
            enter(PH_STOP_MARK, cfg.bit_mark);
          end else begin
            ph = PH_IDLE;
            frame = 0; bits = 0; remaining = 0; sub = 0; carrier = 0; level = 0;
            return 1'b1;
          end
        end
        PH_STOP_MARK:  enter(PH_STOP_SPACE, cfg.stop_space);
        PH_STOP_SPACE: begin
          frame = 1;
          enter(PH_LEAD_MARK, cfg.leader_mark);
        end
        default: ph = PH_IDLE;
      endcase
      return 1'b0;
    endfunction

    function res_t step_emitter(bit action, logic [DATA_W-1:0] data);
      res_t        r;
      int unsigned hp;
      r = '0;
      if (action == ACT_START) begin
        if (ph != PH_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          code = CODE_BITS'(data);
          frame = 0;
          bits = 0;
          enter(PH_LEAD_MARK, cfg.leader_mark);
        end
      end else if (ph != PH_IDLE) begin
        if (carrier_gated(ph)) begin
          hp = (cfg.half_period == '0) ? 1 : cfg.half_period;
          r.envelope = 1'b1;
          r.ir_out = level;
          carrier++;
          if (carrier >= hp) begin
            carrier = 0;
            level = ~level;
          end
        end
        sub++;
        if (sub >= TICKS_PER_US) begin
          sub = 0;
          if (remaining > 0) remaining--;
          if (remaining == 0) r.done_res = advance();
        end
      end
      r.busy_res = (ph != PH_IDLE);
      return r;
    endfunction

    function void note_request(bit action, logic [DATA_W-1:0] data);
      pending_flags.push_back(step_emitter(action, data));
      accepted++;
    endfunction

    function void report(string field, int got, int want);
      $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
      mismatches++;
    endfunction

    function void check_flags(logic [OUT_W-1:0] tdata);
      res_t got, want;
      got = res_t'(tdata[4:0]);
      if (pending_flags.size() == 0) begin
        report("unexpected result", tdata, 0);
      end else begin
        want = pending_flags.pop_front();
        if (got.ir_out   !== want.ir_out)   report("ir_out", got.ir_out, want.ir_out);
        if (got.envelope !== want.envelope) report("envelope", got.envelope, want.envelope);
        if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
        if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
        if (got.rejected !== want.rejected) report("rejected", got.rejected, want.rejected);
        if (tdata[OUT_W-1:5] !== '0) report("pad bits", tdata[OUT_W-1:5], 0);
      end
      results_seen++;
    endfunction
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  ir_frame_scoreboard sb = new();
  bit calm = 1'b0;
  int cycles = 0;

  ir_pulse_distance_transmitter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_flags(m_tdata);
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pick_frame();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return {24{2'b10}};
      3: return {24{2'b01}};
      4: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return rand48();
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_setting(int idx);
    logic [CFG_W-1:0] v;
    int               r;
    r = $urandom_range(0, 99);
    if (idx == REG_HALF_PERIOD) begin
      if (r < 10) v = '0;
      else if (r < 20) v = 16'd1;
      else if (r < 28) v = 16'hFFFF;
      else v = $urandom_range(2, 24);
    end else begin
      if (r < 20) v = '0;
      else if (r < 85) v = 16'd1;
      else if (r < 97) v = 16'd2;
      else v = 16'd3;
      // bits above the register width are dropped
      if ($urandom_range(0, 9) == 0) v[CFG_W-1:US_W] = $urandom_range(1, 7);
    end
    return v;
  endfunction

  // receiver side: bursts of ready with random stalls
  initial begin
    int hold;
    int stall;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // valid stays high after a request is taken until the next call decides
  task automatic send_request(bit action, logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(action, data);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ticks until the transmission ends, with stray starts and occasional retuning
  task automatic run_to_idle();
    int idx;
    while (sb.ph != PH_IDLE) begin
      if ($urandom_range(0, 599) == 0) begin
        drain();
        idx = $urandom_range(0, 6);
        write_config(IDX_W'(idx), pick_setting(idx));
      end
      if ($urandom_range(0, 49) == 0) send_request(ACT_START, rand48());
      else send_request(ACT_TICK, rand48());
    end
  endtask

  task automatic random_round();
    int n;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 7; i++) write_config(IDX_W'(i), pick_setting(i));
    n = $urandom_range(0, 4);
    repeat (n) send_request(ACT_TICK, rand48());
    send_request(ACT_START, pick_frame());
    run_to_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle ticks, then an unused register index
    send_request(ACT_TICK, '1);
    send_request(ACT_TICK, '0);
    drain();
    write_config(REG_UNUSED, 16'hFFFF);

    // one full transmission on short timing, then idle ticks
    random_round();
    while (sb.accepted < RANDOM_ITEMS) send_request(ACT_TICK, rand48());

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_flags.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: ir_pulse_distance_transmitter.f
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_cfg.sv
hw/rtl/irpd_core.sv
hw/rtl/ir_pulse_distance_transmitter.sv
verif/tb_ir_pulse_distance_transmitter.sv
